### hdl/pcma_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcma_pkg
// Shared types and constants of the modular coefficient ALU.
// ----------------------------------------------------------------------------
package pcma_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned COEF_W  = 32;
  localparam int unsigned NORM_W  = 31;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ADDR_W  = 3;

  typedef enum logic [OP_W-1:0] {
    OP_ADD  = 2'd0,
    OP_SUB  = 2'd1,
    OP_MUL  = 2'd2,
    OP_NORM = 2'd3
  } opcode_e;

  localparam logic REG_MODULUS = 1'b0;
  localparam logic REG_SCALAR  = 1'b1;

  localparam logic [DATA_W-1:0] MODULUS_RESET = 32'd3329;
  localparam logic [DATA_W-1:0] SCALAR_RESET  = 32'd1;

  localparam logic [NORM_W-1:0] NORM_MAX = 31'h7FFF_FFFF;

endpackage
`default_nettype wire

### hdl/pcma_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcma_in_if / pcma_out_if
// Valid/ready channels for coefficient items and result items.
// ----------------------------------------------------------------------------
interface pcma_in_if;
  import pcma_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [COEF_W-1:0] coeff_a;
  logic [COEF_W-1:0] coeff_b;
  logic              last_in;

  modport source (output valid, opcode, coeff_a, coeff_b, last_in, input ready);
  modport sink   (input valid, opcode, coeff_a, coeff_b, last_in, output ready);
endinterface

interface pcma_out_if;
  import pcma_pkg::*;

  logic              valid;
  logic              ready;
  logic [COEF_W-1:0] result_coeff;
  logic [NORM_W-1:0] norm_so_far;
  logic              last_out;

  modport source (output valid, result_coeff, norm_so_far, last_out, input ready);
  modport sink   (input valid, result_coeff, norm_so_far, last_out, output ready);
endinterface
`default_nettype wire

### hdl/poly_coeff_mod_alu_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// poly_coeff_mod_alu_core
// Modular add, subtract, scalar multiply and centered magnitude of polynomial
// coefficients, with a running infinity-norm maximum.
// ----------------------------------------------------------------------------
// One item at a time: a new item is taken only in the idle state, after the
// last one has passed the bit-serial reduction (and, for scalar multiply, the
// bit-serial modular multiplier) and its result has been registered; a result
// that the sink has not yet taken holds the next result back.
// Reset clears control state and the running maximum, and loads the modulus
// with 3329 and the scalar factor with 1.
// ----------------------------------------------------------------------------
module poly_coeff_mod_alu_core #(
  parameter int unsigned COEFF_WIDTH = 32
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  pcma_in_if.sink                      in_i,
  pcma_out_if.source                   out_o,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [pcma_pkg::ADDR_W-1:0]   paddr,
  input  wire [pcma_pkg::DATA_W-1:0]   pwdata,
  output logic [pcma_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import pcma_pkg::*;

  localparam int unsigned W     = COEFF_WIDTH;
  localparam int unsigned QW    = COEFF_WIDTH + 1;
  localparam int unsigned CNT_W = $clog2(COEFF_WIDTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RED  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [DATA_W-1:0] modulus_q, scalar_q;
  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [OP_W-1:0]   op_q, op_d;
  logic              last_q, last_d;
  logic [W-1:0]      a_sh_q, a_sh_d, b_sh_q, b_sh_d, s_sh_q, s_sh_d;
  logic [W-1:0]      ra_q, ra_d, rb_q, rb_d, rs_q, rs_d, rm_q, rm_d;
  logic [W-1:0]      max_q, max_d;
  logic              out_valid_q, out_valid_d;
  logic [COEF_W-1:0] out_res_q, out_res_d;
  logic [NORM_W-1:0] out_norm_q, out_norm_d;
  logic              out_last_q, out_last_d;

  logic [QW-1:0]     q_eff;
  logic [W-1:0]      mod_w;
  logic              in_xfer, out_xfer, cnt_done;
  logic [QW-1:0]     sum_w, res_w, half_q;
  logic [W-1:0]      new_max;
  logic [32:0]       max_ext;

  function automatic logic [W-1:0] red_step(input logic [W-1:0] r, input logic b,
                                           input logic [QW-1:0] q);
    logic [QW-1:0] t;
    t = {r, b};
    if (t >= q) begin
      t = t - q;
    end
    return t[W-1:0];
  endfunction

  function automatic logic [W-1:0] mul_step(input logic [W-1:0] r, input logic b,
                                           input logic [W-1:0] x,
                                           input logic [QW-1:0] q);
    logic [QW:0] t;
    logic [QW:0] q1;
    logic [QW:0] q2;
    q1 = {1'b0, q};
    q2 = {q, 1'b0};
    t = {1'b0, r, 1'b0} + (b ? {2'b00, x} : '0);
    if (t >= q2) begin
      t = t - q2;
    end else if (t >= q1) begin
      t = t - q1;
    end
    return t[W-1:0];
  endfunction

  // Configuration registers.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SCALAR) ? scalar_q : modulus_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MODULUS_RESET;
      scalar_q  <= SCALAR_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_MODULUS) begin
        modulus_q <= pwdata;
      end else begin
        scalar_q <= pwdata;
      end
    end
  end

  assign mod_w = modulus_q[W-1:0];
  assign q_eff = (mod_w == '0) ? {1'b1, {W{1'b0}}} : {1'b0, mod_w};
  assign half_q = q_eff >> 1;

  assign in_i.ready         = (state_q == ST_IDLE);
  assign in_xfer            = in_i.valid && in_i.ready;
  assign out_xfer           = out_valid_q && out_o.ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.result_coeff = out_res_q;
  assign out_o.norm_so_far  = out_norm_q;
  assign out_o.last_out     = out_last_q;
  assign cnt_done           = (cnt_q == CNT_W'(W - 1));

  always_comb begin
    sum_w = {1'b0, ra_q} + {1'b0, rb_q};
    case (op_q)
      OP_ADD: begin
        res_w = (sum_w >= q_eff) ? sum_w - q_eff : sum_w;
      end
      OP_SUB: begin
        res_w = (ra_q >= rb_q) ? {1'b0, ra_q} - {1'b0, rb_q}
                               : {1'b0, ra_q} + q_eff - {1'b0, rb_q};
      end
      OP_MUL: begin
        res_w = {1'b0, rm_q};
      end
      default: begin
        res_w = ({1'b0, ra_q} > half_q) ? q_eff - {1'b0, ra_q} : {1'b0, ra_q};
      end
    endcase
    new_max = ((op_q == OP_NORM) && (res_w[W-1:0] > max_q)) ? res_w[W-1:0] : max_q;
    max_ext = 33'(new_max);
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    op_d        = op_q;
    last_d      = last_q;
    a_sh_d      = a_sh_q;
    b_sh_d      = b_sh_q;
    s_sh_d      = s_sh_q;
    ra_d        = ra_q;
    rb_d        = rb_q;
    rs_d        = rs_q;
    rm_d        = rm_q;
    max_d       = max_q;
    out_valid_d = out_valid_q && !out_xfer;
    out_res_d   = out_res_q;
    out_norm_d  = out_norm_q;
    out_last_d  = out_last_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          op_d    = in_i.opcode;
          last_d  = in_i.last_in;
          a_sh_d  = in_i.coeff_a[W-1:0];
          b_sh_d  = in_i.coeff_b[W-1:0];
          s_sh_d  = scalar_q[W-1:0];
          ra_d    = '0;
          rb_d    = '0;
          rs_d    = '0;
          cnt_d   = '0;
          state_d = ST_RED;
        end
      end
      ST_RED: begin
        ra_d   = red_step(ra_q, a_sh_q[W-1], q_eff);
        rb_d   = red_step(rb_q, b_sh_q[W-1], q_eff);
        rs_d   = red_step(rs_q, s_sh_q[W-1], q_eff);
        a_sh_d = a_sh_q << 1;
        b_sh_d = b_sh_q << 1;
        s_sh_d = s_sh_q << 1;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_done) begin
          cnt_d = '0;
          if (op_q == OP_MUL) begin
            s_sh_d  = rs_d;
            rm_d    = '0;
            state_d = ST_MUL;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_MUL: begin
        rm_d   = mul_step(rm_q, s_sh_q[W-1], ra_q, q_eff);
        s_sh_d = s_sh_q << 1;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_done) begin
          cnt_d   = '0;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_res_d   = COEF_W'(res_w[W-1:0]);
          out_norm_d  = (max_ext > 33'(NORM_MAX)) ? NORM_MAX : max_ext[NORM_W-1:0];
          out_last_d  = last_q;
          max_d       = last_q ? '0 : new_max;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      max_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      max_q       <= max_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    last_q     <= last_d;
    a_sh_q     <= a_sh_d;
    b_sh_q     <= b_sh_d;
    s_sh_q     <= s_sh_d;
    ra_q       <= ra_d;
    rb_q       <= rb_d;
    rs_q       <= rs_d;
    rm_q       <= rm_d;
    out_res_q  <= out_res_d;
    out_norm_q <= out_norm_d;
    out_last_q <= out_last_d;
  end

endmodule
`default_nettype wire
